@@ src/pm25fc_pkg.sv @@
// Shared types and constants for the PM2.5 frame checker.
// No dependencies; used by pm25fc_grader and pm25_frame_checker.
package pm25fc_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int LIMIT_WIDTH     = 16;
   localparam int CLASS_WIDTH     = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GOOD_LIMIT     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAIR_LIMIT     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MODERATE_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_POOR_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_VERY_POOR_MAX  = 3'd4;

   localparam logic [LIMIT_WIDTH-1:0] RESET_GOOD_LIMIT     = 16'd35;
   localparam logic [LIMIT_WIDTH-1:0] RESET_FAIR_LIMIT     = 16'd75;
   localparam logic [LIMIT_WIDTH-1:0] RESET_MODERATE_LIMIT = 16'd115;
   localparam logic [LIMIT_WIDTH-1:0] RESET_POOR_LIMIT     = 16'd150;
   localparam logic [LIMIT_WIDTH-1:0] RESET_VERY_POOR_MAX  = 16'd500;

   localparam logic [CLASS_WIDTH-1:0] CLASS_UNKNOWN        = 3'd0;
   localparam logic [CLASS_WIDTH-1:0] CLASS_GOOD           = 3'd1;
   localparam logic [CLASS_WIDTH-1:0] CLASS_FAIR           = 3'd2;
   localparam logic [CLASS_WIDTH-1:0] CLASS_MODERATE       = 3'd3;
   localparam logic [CLASS_WIDTH-1:0] CLASS_POOR           = 3'd4;
   localparam logic [CLASS_WIDTH-1:0] CLASS_VERY_POOR      = 3'd5;
   localparam logic [CLASS_WIDTH-1:0] CLASS_EXTREMELY_POOR = 3'd6;

   localparam logic [7:0] HEADER_BYTE0 = 8'h16;
   localparam logic [7:0] HEADER_BYTE1 = 8'h11;
   localparam logic [7:0] HEADER_BYTE2 = 8'h0b;

   localparam int POS_HEADER0 = 0;
   localparam int POS_HEADER1 = 1;
   localparam int POS_HEADER2 = 2;
   localparam int POS_HIGH    = 15;
   localparam int POS_LOW     = 16;

   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] good_limit;
      logic [LIMIT_WIDTH-1:0] fair_limit;
      logic [LIMIT_WIDTH-1:0] moderate_limit;
      logic [LIMIT_WIDTH-1:0] poor_limit;
      logic [LIMIT_WIDTH-1:0] very_poor_max;
   } limits_type;

endpackage

@@ src/pm25fc_grader.sv @@
// Air-quality grading of one PM2.5 reading against the five threshold registers.
// Depends on pm25fc_pkg for the limits struct and class codes.
module pm25fc_grader (
   input  logic [pm25fc_pkg::LIMIT_WIDTH-1:0] value,
   input  pm25fc_pkg::limits_type             limits,
   output logic [pm25fc_pkg::CLASS_WIDTH-1:0] quality_class
);

   always_comb begin
      priority if (value < limits.good_limit) begin
         quality_class = pm25fc_pkg::CLASS_GOOD;
      end else if (value < limits.fair_limit) begin
         quality_class = pm25fc_pkg::CLASS_FAIR;
      end else if (value < limits.moderate_limit) begin
         quality_class = pm25fc_pkg::CLASS_MODERATE;
      end else if (value < limits.poor_limit) begin
         quality_class = pm25fc_pkg::CLASS_POOR;
      end else if (value <= limits.very_poor_max) begin
         quality_class = pm25fc_pkg::CLASS_VERY_POOR;
      end else begin
         quality_class = pm25fc_pkg::CLASS_EXTREMELY_POOR;
      end
   end

endmodule

@@ src/pm25_frame_checker.sv @@
// Top level of the PM2.5 frame checker: input register, frame state and result register.
// Depends on pm25fc_pkg and pm25fc_grader.

// The block takes one transaction per clock cycle, either a reply byte or an
// end-of-response marker, and holds it in an input register; from that
// register it updates the frame state and, for a marker, loads the result
// register. A marker waits only while the previous result has not yet been
// taken, since the single result register is the only buffer there, and
// anything behind it waits in turn.
// Thresholds must be written while no transaction is in flight.
module pm25_frame_checker #(
   parameter int FRAME_LENGTH = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] frame_valid, [16:1] pm_reading, [19:17] quality_class
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [pm25fc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pm25fc_pkg::LIMIT_WIDTH-1:0]     csr_data
);

   localparam int CountWidth = $clog2(FRAME_LENGTH + 1);
   localparam logic [CountWidth-1:0] FrameCount = CountWidth'(FRAME_LENGTH);

   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff;
   logic [7:0] in_byte_ff;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            sum_ff, sum_in;
   logic                  header_good_ff, header_good_in;
   logic [7:0]            high_ff, high_in;
   logic [7:0]            low_ff, low_in;
   logic [15:0]           last_ff, last_in;

   pm25fc_pkg::limits_type limits_ff, limits_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_frame_valid_ff;
   logic [15:0]                          rsp_pm25_ff;
   logic [pm25fc_pkg::CLASS_WIDTH-1:0]   rsp_class_ff;

   logic                               advance;
   logic                               take_byte;
   logic                               marker;
   logic                               frame_ok;
   logic [15:0]                        reading;
   logic [pm25fc_pkg::CLASS_WIDTH-1:0] graded_class;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!in_kind_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take_byte  = advance && !in_kind_ff && (count_ff < FrameCount);
   assign marker     = advance && in_kind_ff;
   assign reading    = {high_ff, low_ff};
   assign frame_ok   = (count_ff == FrameCount) && header_good_ff && (sum_ff == 8'd0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_class_ff, rsp_pm25_ff, rsp_frame_valid_ff};

   pm25fc_grader u_grader (
      .value         (reading),
      .limits        (limits_ff),
      .quality_class (graded_class)
   );

   always_comb begin
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      rsp_valid_in = marker ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      count_in       = count_ff;
      sum_in         = sum_ff;
      header_good_in = header_good_ff;
      high_in        = high_ff;
      low_in         = low_ff;
      last_in        = last_ff;
      if (take_byte) begin
         if (count_ff == CountWidth'(pm25fc_pkg::POS_HEADER0)
             && in_byte_ff != pm25fc_pkg::HEADER_BYTE0) begin
            header_good_in = 1'b0;
         end
         if (count_ff == CountWidth'(pm25fc_pkg::POS_HEADER1)
             && in_byte_ff != pm25fc_pkg::HEADER_BYTE1) begin
            header_good_in = 1'b0;
         end
         if (count_ff == CountWidth'(pm25fc_pkg::POS_HEADER2)
             && in_byte_ff != pm25fc_pkg::HEADER_BYTE2) begin
            header_good_in = 1'b0;
         end
         if (count_ff == CountWidth'(pm25fc_pkg::POS_HIGH)) begin
            high_in = in_byte_ff;
         end
         if (count_ff == CountWidth'(pm25fc_pkg::POS_LOW)) begin
            low_in = in_byte_ff;
         end
         sum_in   = sum_ff + in_byte_ff;
         count_in = count_ff + CountWidth'(1);
      end
      if (marker) begin
         if (frame_ok) begin
            last_in = reading;
         end
         count_in       = '0;
         sum_in         = 8'd0;
         header_good_in = 1'b1;
         high_in        = 8'd0;
         low_in         = 8'd0;
      end
   end

   always_comb begin
      limits_in = limits_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pm25fc_pkg::REG_GOOD_LIMIT:     limits_in.good_limit     = csr_data;
            pm25fc_pkg::REG_FAIR_LIMIT:     limits_in.fair_limit     = csr_data;
            pm25fc_pkg::REG_MODERATE_LIMIT: limits_in.moderate_limit = csr_data;
            pm25fc_pkg::REG_POOR_LIMIT:     limits_in.poor_limit     = csr_data;
            pm25fc_pkg::REG_VERY_POOR_MAX:  limits_in.very_poor_max  = csr_data;
            default:                        limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         count_ff                <= '0;
         sum_ff                  <= 8'd0;
         header_good_ff          <= 1'b1;
         high_ff                 <= 8'd0;
         low_ff                  <= 8'd0;
         last_ff                 <= 16'd0;
         limits_ff.good_limit     <= pm25fc_pkg::RESET_GOOD_LIMIT;
         limits_ff.fair_limit     <= pm25fc_pkg::RESET_FAIR_LIMIT;
         limits_ff.moderate_limit <= pm25fc_pkg::RESET_MODERATE_LIMIT;
         limits_ff.poor_limit     <= pm25fc_pkg::RESET_POOR_LIMIT;
         limits_ff.very_poor_max  <= pm25fc_pkg::RESET_VERY_POOR_MAX;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         header_good_ff <= header_good_in;
         high_ff        <= high_in;
         low_ff         <= low_in;
         last_ff        <= last_in;
         limits_ff      <= limits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (marker) begin
         rsp_frame_valid_ff <= frame_ok;
         rsp_pm25_ff        <= frame_ok ? reading : last_ff;
         rsp_class_ff       <= frame_ok ? graded_class : pm25fc_pkg::CLASS_UNKNOWN;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FrameCount)
      else $error("byte count passed the frame length");

   a_marker_clears: assert property (@(posedge clock) disable iff (reset)
      marker |=> (count_ff == '0) && header_good_ff && (sum_ff == 8'd0))
      else $error("frame state not cleared after a marker");

   a_valid_has_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_frame_valid_ff == (rsp_class_ff != pm25fc_pkg::CLASS_UNKNOWN)))
      else $error("quality class disagrees with frame_valid");

   a_pm25_tracks_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_frame_valid_ff |-> (rsp_pm25_ff == last_ff))
      else $error("invalid result does not repeat the last reading");

endmodule
